FILE: rtl/window_mean_stddev_filter_unit_assert.svh
// assertion macros shared by the window mean / deviation filter rtl
// expects i_clk and i_rst_n to be visible at the place of use
`ifndef WINDOW_MEAN_STDDEV_FILTER_UNIT_ASSERT_SVH
`define WINDOW_MEAN_STDDEV_FILTER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WMSF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wmsf: same-cycle check failed");

// next-cycle implication, checked outside reset
`define WMSF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wmsf: next-cycle check failed");

`endif

FILE: rtl/wmsf_pkg.sv
// shared constants, codes and types of the window mean / deviation filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wmsf_pkg;

    localparam int WINDOW = 16;
    localparam int DATA_W = 16;
    localparam int FILL_W = 5;
    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    // running sum of the window
    localparam int SUM_W  = DATA_W + PTR_W;
    // squared deviation accumulator
    localparam int ACC_W  = 2 * DATA_W + PTR_W;
    // divisor width, covers the incremented scaled values
    localparam int DIV_D  = SUM_W + 1;
    // numerator width of the repeat count division
    localparam int CNUM_W = DIV_D + PTR_W;
    // partial remainder width of the shared unit
    localparam int AW     = DIV_D + 2;
    localparam int STEP_W = $clog2(ACC_W + 1);

    localparam logic CMD_PLAIN    = 1'b0;
    localparam logic CMD_WEIGHTED = 1'b1;

    typedef enum logic {
        ALU_DIV  = 1'b0,
        ALU_SQRT = 1'b1
    } t_alu_mode;

    typedef struct packed {
        logic               start;
        t_alu_mode          mode;
        logic [ACC_W-1:0]   operand;
        logic [DIV_D-1:0]   divisor;
        logic [STEP_W-1:0]  steps;
    } t_alu_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [ACC_W-1:0]   result;
    } t_alu_rsp;

endpackage

`default_nettype wire

FILE: rtl/wmsf_if.sv
// valid/ready channel interfaces for samples in and statistics out
// depends on wmsf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface wmsf_in_if import wmsf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [DATA_W-1:0] sample;
    logic [DATA_W-1:0] reference_average;

    modport source (output valid, cmd, sample, reference_average, input ready);
    modport sink   (input valid, cmd, sample, reference_average, output ready);
endinterface

interface wmsf_out_if import wmsf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] mean;
    logic [DATA_W-1:0] deviation;
    logic [FILL_W-1:0] fill_count;
    logic              error;

    modport source (output valid, mean, deviation, fill_count, error, input ready);
    modport sink   (input valid, mean, deviation, fill_count, error, output ready);
endinterface

`default_nettype wire

FILE: rtl/window_mean_stddev_filter_unit.sv
// Moving-window mean and standard deviation filter, top level.
// Input channel i_in carries cmd, sample and reference_average; a transaction
// happens when valid and ready are both high. Output channel o_out returns one
// transaction per input: mean, deviation, fill_count and error.
// cmd plain writes the sample once; cmd weighted scales the old mean and the
// sample by WINDOW/reference_average and writes the sample 1 to WINDOW/2 times.
// Each write runs the mean division, a walk over the window that squares
// each entry's deviation, the variance division and the square root on the
// shared divide/square root unit, which resolves one bit per cycle. A weighted
// add costs three more divisions before its writes. A zero reference goes
// straight to the output with error set. The block takes one input at a time:
// ready is high only while it waits for work. A finished result sits in an
// output register, so the next input is taken while the receiver stalls; the
// block then holds its next result until the register is free.
// Reset (synchronous, active low) empties the window: fill count, sum, mean
// and deviation return to zero; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "window_mean_stddev_filter_unit_assert.svh"

module window_mean_stddev_filter_unit import wmsf_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wmsf_in_if.sink    i_in,
    wmsf_out_if.source o_out
);

    typedef enum logic [17:0] {
        S_IDLE   = 18'h00001,
        S_LO     = 18'h00002,
        S_LO_W   = 18'h00004,
        S_HI     = 18'h00008,
        S_HI_W   = 18'h00010,
        S_ORDER  = 18'h00020,
        S_CNT    = 18'h00040,
        S_CNT_W  = 18'h00080,
        S_INS    = 18'h00100,
        S_MEAN   = 18'h00200,
        S_MEAN_W = 18'h00400,
        S_WALK   = 18'h00800,
        S_ACC    = 18'h01000,
        S_VAR    = 18'h02000,
        S_VAR_W  = 18'h04000,
        S_SQRT   = 18'h08000,
        S_SQRT_W = 18'h10000,
        S_OUT    = 18'h20000
    } t_state;

    t_state              r_state;
    t_state              n_state;

    logic [DATA_W-1:0]   r_hist [WINDOW];
    logic [PTR_W-1:0]    r_wp;
    logic [CNT_W-1:0]    r_filled;
    logic [SUM_W-1:0]    r_sum;
    logic [DATA_W-1:0]   r_mean;
    logic [DATA_W-1:0]   r_dev;

    logic [DATA_W-1:0]   r_sample;
    logic [DATA_W-1:0]   r_ref;
    logic                r_err;
    logic [CNT_W-1:0]    r_reps;
    logic [DIV_D-1:0]    r_lo;
    logic [DIV_D-1:0]    r_hi;
    logic [PTR_W-1:0]    r_idx;
    logic [2*DATA_W-1:0] r_sq;
    logic [ACC_W-1:0]    r_acc;

    logic                r_ovalid;
    logic [DATA_W-1:0]   r_omean;
    logic [DATA_W-1:0]   r_odev;
    logic [FILL_W-1:0]   r_ofill;
    logic                r_oerr;

    t_alu_req            alu_req;
    t_alu_rsp            alu_rsp;

    logic                w_accept;
    logic                w_zero_ref;
    logic                w_out_free;
    logic                w_full;
    logic                w_walk_last;
    logic [DATA_W-1:0]   w_old;
    logic [DATA_W-1:0]   w_rd;
    logic [DATA_W-1:0]   w_absdiff;
    logic [ACC_W-1:0]    w_q;
    logic [CNT_W-1:0]    w_cntq;
    logic [CNT_W-1:0]    w_reps;

    wmsf_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid & i_in.ready;
    assign w_zero_ref = (i_in.cmd == CMD_WEIGHTED) && (i_in.reference_average == '0);
    assign w_out_free = ~r_ovalid | o_out.ready;
    assign w_full     = (r_filled == CNT_W'(WINDOW));
    assign w_walk_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_filled);

    // the slot being overwritten holds a sample only once the window is full
    assign w_old     = w_full ? r_hist[r_wp] : '0;
    assign w_rd      = r_hist[r_idx];
    assign w_absdiff = (r_mean >= w_rd) ? (r_mean - w_rd) : (w_rd - r_mean);
    assign w_q       = alu_rsp.result;
    assign w_cntq    = w_q[CNT_W-1:0];

    always_comb begin
        if (w_cntq == '0) begin
            w_reps = CNT_W'(1);
        end else if (w_cntq > CNT_W'(2)) begin
            w_reps = w_cntq >> 1;
        end else begin
            w_reps = w_cntq;
        end
    end

    always_comb begin
        alu_req = '0;
        case (r_state)
            S_LO: begin
                alu_req.start   = 1'b1;
                alu_req.operand = ACC_W'(SUM_W'(r_mean) * SUM_W'(WINDOW)) << (ACC_W - SUM_W);
                alu_req.divisor = DIV_D'(r_ref);
                alu_req.steps   = STEP_W'(SUM_W);
            end
            S_HI: begin
                alu_req.start   = 1'b1;
                alu_req.operand = ACC_W'(SUM_W'(r_sample) * SUM_W'(WINDOW)) << (ACC_W - SUM_W);
                alu_req.divisor = DIV_D'(r_ref);
                alu_req.steps   = STEP_W'(SUM_W);
            end
            S_CNT: begin
                alu_req.start   = 1'b1;
                alu_req.operand = ACC_W'(CNUM_W'(r_hi - r_lo + DIV_D'(1)) * CNUM_W'(WINDOW))
                                  << (ACC_W - CNUM_W);
                alu_req.divisor = r_hi;
                alu_req.steps   = STEP_W'(CNUM_W);
            end
            S_MEAN: begin
                alu_req.start   = 1'b1;
                alu_req.operand = ACC_W'(r_sum) << (ACC_W - SUM_W);
                alu_req.divisor = DIV_D'(r_filled);
                alu_req.steps   = STEP_W'(SUM_W);
            end
            S_VAR: begin
                alu_req.start   = 1'b1;
                alu_req.operand = r_acc;
                alu_req.divisor = DIV_D'(r_filled);
                alu_req.steps   = STEP_W'(ACC_W);
            end
            S_SQRT: begin
                // mean squared deviation stays below 2**(2*DATA_W)
                alu_req.start   = 1'b1;
                alu_req.mode    = ALU_SQRT;
                alu_req.operand = ACC_W'(w_q[2*DATA_W-1:0]) << (ACC_W - 2 * DATA_W);
                alu_req.steps   = STEP_W'(DATA_W);
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.cmd == CMD_PLAIN) begin
                        n_state = S_INS;
                    end else if (i_in.reference_average == '0) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_LO;
                    end
                end
            end
            S_LO:     n_state = S_LO_W;
            S_LO_W:   if (alu_rsp.done) n_state = S_HI;
            S_HI:     n_state = S_HI_W;
            S_HI_W:   if (alu_rsp.done) n_state = S_ORDER;
            S_ORDER:  n_state = S_CNT;
            S_CNT:    n_state = S_CNT_W;
            S_CNT_W:  if (alu_rsp.done) n_state = S_INS;
            S_INS:    n_state = S_MEAN;
            S_MEAN:   n_state = S_MEAN_W;
            S_MEAN_W: if (alu_rsp.done) n_state = S_WALK;
            S_WALK:   n_state = S_ACC;
            S_ACC:    n_state = w_walk_last ? S_VAR : S_WALK;
            S_VAR:    n_state = S_VAR_W;
            S_VAR_W:  if (alu_rsp.done) n_state = S_SQRT;
            S_SQRT:   n_state = S_SQRT_W;
            S_SQRT_W: begin
                if (alu_rsp.done) begin
                    n_state = (r_reps == CNT_W'(1)) ? S_OUT : S_INS;
                end
            end
            S_OUT:    if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_wp     <= '0;
            r_filled <= '0;
            r_sum    <= '0;
            r_mean   <= '0;
            r_dev    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_INS) begin
                r_wp <= (r_wp == PTR_W'(WINDOW - 1)) ? '0 : r_wp + PTR_W'(1);
                if (!w_full) begin
                    r_filled <= r_filled + CNT_W'(1);
                end
                r_sum <= r_sum + SUM_W'(r_sample) - SUM_W'(w_old);
            end
            if (r_state == S_MEAN_W && alu_rsp.done) begin
                r_mean <= w_q[DATA_W-1:0];
            end
            if (r_state == S_SQRT_W && alu_rsp.done) begin
                r_dev <= w_q[DATA_W-1:0];
            end
        end
    end

    // working registers of the current transaction
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_sample <= i_in.sample;
                    r_ref    <= i_in.reference_average;
                    r_err    <= (i_in.cmd == CMD_WEIGHTED) && (i_in.reference_average == '0);
                    r_reps   <= CNT_W'(1);
                end
            end
            S_LO_W: begin
                if (alu_rsp.done) r_lo <= DIV_D'(w_q[SUM_W-1:0]);
            end
            S_HI_W: begin
                if (alu_rsp.done) r_hi <= DIV_D'(w_q[SUM_W-1:0]);
            end
            S_ORDER: begin
                if (r_lo > r_hi) begin
                    r_lo <= r_hi + DIV_D'(1);
                    r_hi <= r_lo + DIV_D'(1);
                end else begin
                    r_lo <= r_lo + DIV_D'(1);
                    r_hi <= r_hi + DIV_D'(1);
                end
            end
            S_CNT_W: begin
                if (alu_rsp.done) r_reps <= w_reps;
            end
            S_INS: begin
                r_hist[r_wp] <= r_sample;
            end
            S_MEAN_W: begin
                r_idx <= '0;
                r_acc <= '0;
            end
            S_WALK: begin
                r_sq <= w_absdiff * w_absdiff;
            end
            S_ACC: begin
                r_acc <= r_acc + ACC_W'(r_sq);
                r_idx <= r_idx + PTR_W'(1);
            end
            S_SQRT_W: begin
                if (alu_rsp.done) r_reps <= r_reps - CNT_W'(1);
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_omean <= r_mean;
                    r_odev  <= r_dev;
                    r_ofill <= FILL_W'(r_filled);
                    r_oerr  <= r_err;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.mean       = r_omean;
    assign o_out.deviation  = r_odev;
    assign o_out.fill_count = r_ofill;
    assign o_out.error      = r_oerr;

    // until the window wraps the write slot equals the fill count
    `WMSF_ASSERT_IMP(a_ptr_tracks_fill, r_filled < CNT_W'(WINDOW), CNT_W'(r_wp) == r_filled)
    `WMSF_ASSERT_IMP(a_alu_start_idle, alu_req.start, !alu_rsp.busy)
    `WMSF_ASSERT_IMP(a_reps_range, r_state == S_INS, (r_reps != '0) && (r_reps <= CNT_W'(WINDOW / 2)))
    `WMSF_ASSERT_NXT(a_zero_ref_error, w_accept && w_zero_ref, (r_state == S_OUT) && r_err)

endmodule

`default_nettype wire

FILE: rtl/wmsf_alu.sv
// shared shift/compare/subtract unit: restoring divide or integer square root,
// one quotient or root bit per cycle; depends on wmsf_pkg
`timescale 1ns / 1ps
`default_nettype none

module wmsf_alu import wmsf_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    t_alu_mode         r_mode;
    logic [ACC_W-1:0]  r_num;
    logic [ACC_W-1:0]  r_q;
    logic [DIV_D-1:0]  r_div;
    logic [AW-1:0]     r_rem;

    logic [AW-1:0]     w_trial;
    logic [AW-1:0]     w_sub;
    logic [AW:0]       w_diff;
    logic              w_ge;

    // operand is left aligned: the top bits feed the partial remainder
    always_comb begin
        if (r_mode == ALU_SQRT) begin
            w_trial = {r_rem[AW-3:0], r_num[ACC_W-1 -: 2]};
            w_sub   = {r_q[AW-3:0], 2'b01};
        end else begin
            w_trial = {r_rem[AW-2:0], r_num[ACC_W-1]};
            w_sub   = AW'(r_div);
        end
        w_diff = {1'b0, w_trial} - {1'b0, w_sub};
        w_ge   = ~w_diff[AW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mode <= i_req.mode;
            r_num  <= i_req.operand;
            r_div  <= i_req.divisor;
            r_rem  <= '0;
            r_q    <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[AW-1:0] : w_trial;
            r_q   <= {r_q[ACC_W-2:0], w_ge};
            if (r_mode == ALU_SQRT) begin
                r_num <= {r_num[ACC_W-3:0], 2'b00};
            end else begin
                r_num <= {r_num[ACC_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_q;

endmodule

`default_nettype wire
